/* rtl/geffe_pkg.sv */
`timescale 1ns / 1ps

package geffe_pkg;

    // register lengths of the three lfsrs
    localparam int LEN_ONE   = 4;
    localparam int LEN_TWO   = 6;
    localparam int LEN_THREE = 8;
    localparam int TOTAL_LEN = LEN_ONE + LEN_TWO + LEN_THREE;

    // visited map: 32 state bits per memory row, each row tagged with an epoch
    localparam int POS_W     = 5;
    localparam int ROW_BITS  = 1 << POS_W;
    localparam int ROW_AW    = TOTAL_LEN - POS_W;
    localparam int ROW_DEPTH = 1 << ROW_AW;
    localparam int EPOCH_W   = 8;
    localparam int ROW_W     = EPOCH_W + ROW_BITS;

    // byte handling
    localparam int BYTE_W    = 8;
    localparam int BYTE_BITS = 8;
    localparam int BIT_IDX_W = 3;
    localparam int CNT_W     = 4;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_MAX_12 = (LEN_ONE > LEN_TWO) ? LEN_ONE : LEN_TWO;
    localparam int CFG_DATA_W = (CFG_MAX_12 > LEN_THREE) ? CFG_MAX_12 : LEN_THREE;

    localparam logic [CFG_IDX_W-1:0] CFG_TAPS_ONE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TAPS_TWO   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_TAPS_THREE = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_ONE   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_TWO   = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_THREE = CFG_IDX_W'(5);

    // reset values of the registers
    localparam logic [LEN_ONE-1:0]   TAPS_ONE_RST   = LEN_ONE'(3);
    localparam logic [LEN_TWO-1:0]   TAPS_TWO_RST   = LEN_TWO'(3);
    localparam logic [LEN_THREE-1:0] TAPS_THREE_RST = LEN_THREE'(29);
    localparam logic [LEN_ONE-1:0]   SEED_ONE_RST   = LEN_ONE'(5);
    localparam logic [LEN_TWO-1:0]   SEED_TWO_RST   = LEN_TWO'(5);
    localparam logic [LEN_THREE-1:0] SEED_THREE_RST = LEN_THREE'(5);

    // controller to datapath
    typedef struct packed {
        logic start;     // item accepted this cycle
        logic clear;     // write one zeroed row of the visited map
        logic run;       // bit loop may issue map reads
        logic load_out;  // move the result into the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_last;  // clearing sweep is at its last row
        logic run_busy;    // bits still to issue or in flight
        logic epoch_full;  // epoch counter at its top value
        logic out_free;    // output register can take a result
    } t_sts;

endpackage

/* rtl/geffe_in_if.sv */
`timescale 1ns / 1ps

// plaintext item channel
interface geffe_in_if import geffe_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] plain_byte;
    logic              first_byte;

    modport source(output valid, plain_byte, first_byte, input ready);
    modport sink(input valid, plain_byte, first_byte, output ready);
endinterface

/* rtl/geffe_out_if.sv */
`timescale 1ns / 1ps

// ciphertext item channel
interface geffe_out_if import geffe_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] cipher_byte;
    logic [BYTE_W-1:0] key_byte;
    logic [CNT_W-1:0]  bits_valid;
    logic              stream_exhausted;

    modport source(output valid, cipher_byte, key_byte, bits_valid, stream_exhausted,
                   input ready);
    modport sink(input valid, cipher_byte, key_byte, bits_valid, stream_exhausted,
                 output ready);
endinterface

/* rtl/geffe_ram.sv */
`timescale 1ns / 1ps

// simple dual port ram, one write and one registered read per cycle
module geffe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/geffe_ctrl.sv */
`timescale 1ns / 1ps

module geffe_ctrl import geffe_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_first_byte,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_ready
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_RUN   = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_pending, n_pending;
    t_cmd   w_cmd;

    // next state and commands
    always_comb begin
        n_state   = r_state;
        n_pending = r_pending;
        w_cmd     = '0;
        unique case (r_state)
            S_CLEAR: begin
                w_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state   = r_pending ? S_RUN : S_IDLE;
                    n_pending = 1'b0;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.start = 1'b1;
                    if (i_first_byte && i_sts.epoch_full) begin
                        n_state   = S_CLEAR;
                        n_pending = 1'b1;
                    end else begin
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                w_cmd.run = 1'b1;
                if (!i_sts.run_busy) begin
                    if (i_sts.out_free) begin
                        w_cmd.load_out = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    w_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register, a clearing sweep runs right after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_pending <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pending <= n_pending;
        end
    end

    assign o_cmd      = w_cmd;
    assign o_in_ready = (r_state == S_IDLE);

endmodule

/* rtl/geffe_dp.sv */
`timescale 1ns / 1ps

module geffe_dp import geffe_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic [BYTE_W-1:0]     i_plain_byte,
    input  logic                  i_first_byte,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [BYTE_W-1:0]     o_cipher_byte,
    output logic [BYTE_W-1:0]     o_key_byte,
    output logic [CNT_W-1:0]      o_bits_valid,
    output logic                  o_stream_exhausted
);

    // configuration registers
    logic [LEN_ONE-1:0]   r_taps_one,   r_seed_one;
    logic [LEN_TWO-1:0]   r_taps_two,   r_seed_two;
    logic [LEN_THREE-1:0] r_taps_three, r_seed_three;

    // lfsrs and message state
    logic [LEN_ONE-1:0]   r_shift_one;
    logic [LEN_TWO-1:0]   r_shift_two;
    logic [LEN_THREE-1:0] r_shift_three;
    logic [EPOCH_W-1:0]   r_epoch;
    logic [ROW_AW-1:0]    r_clr_addr;
    logic                 r_exh;

    // per item working registers
    logic [BYTE_W-1:0]    r_plain, r_key, r_cipher;
    logic [CNT_W-1:0]     r_cnt, r_issue;

    // map lookup stage
    logic                 r_p_valid;
    logic [ROW_AW-1:0]    r_p_row;
    logic [POS_W-1:0]     r_p_pos;
    logic                 r_p_kbit;
    logic [BIT_IDX_W-1:0] r_p_bit;

    // last written row, for a read issued in the same cycle as that write
    logic                 r_byp_valid;
    logic [ROW_AW-1:0]    r_byp_row;
    logic [ROW_BITS-1:0]  r_byp_bits;

    // output register
    logic                 r_out_valid;
    logic [BYTE_W-1:0]    r_out_cipher, r_out_key;
    logic [CNT_W-1:0]     r_out_cnt;
    logic                 r_out_exh;

    logic [TOTAL_LEN-1:0] w_idx;
    logic [ROW_AW-1:0]    w_rd_row;
    logic [POS_W-1:0]     w_rd_pos;
    logic                 w_kbit;
    logic [LEN_ONE-1:0]   w_next_one;
    logic [LEN_TWO-1:0]   w_next_two;
    logic [LEN_THREE-1:0] w_next_three;
    logic [ROW_W-1:0]     w_rdata;
    logic [ROW_BITS-1:0]  w_row_bits, w_new_bits;
    logic                 w_repeat, w_issue;
    logic [BIT_IDX_W-1:0] w_slot;
    logic [BYTE_W-1:0]    n_key, n_cipher;
    logic                 w_we;
    logic [ROW_AW-1:0]    w_waddr;
    logic [ROW_W-1:0]     w_wdata;

    // joined state addresses the map, lfsr step and geffe combiner
    assign w_idx        = {r_shift_one, r_shift_two, r_shift_three};
    assign w_rd_row     = w_idx[TOTAL_LEN-1:POS_W];
    assign w_rd_pos     = w_idx[POS_W-1:0];
    assign w_next_one   = {^(r_shift_one & r_taps_one), r_shift_one[LEN_ONE-1:1]};
    assign w_next_two   = {^(r_shift_two & r_taps_two), r_shift_two[LEN_TWO-1:1]};
    assign w_next_three = {^(r_shift_three & r_taps_three), r_shift_three[LEN_THREE-1:1]};
    assign w_kbit       = r_shift_three[0] ? r_shift_two[0] : r_shift_one[0];

    // row as seen in this epoch, plus the mark for the current bit
    always_comb begin
        if (r_byp_valid && (r_byp_row == r_p_row)) begin
            w_row_bits = r_byp_bits;
        end else if (w_rdata[ROW_W-1 -: EPOCH_W] == r_epoch) begin
            w_row_bits = w_rdata[ROW_BITS-1:0];
        end else begin
            w_row_bits = '0;
        end
        w_new_bits          = w_row_bits;
        w_new_bits[r_p_pos] = 1'b1;
    end

    assign w_repeat = r_p_valid && w_row_bits[r_p_pos];
    assign w_issue  = i_cmd.run && (r_issue != CNT_W'(BYTE_BITS)) && !r_exh && !w_repeat;

    // key and cipher bit into the byte, msb first
    always_comb begin
        w_slot           = BIT_IDX_W'(BYTE_BITS - 1) - r_p_bit;
        n_key            = r_key;
        n_cipher         = r_cipher;
        n_key[w_slot]    = r_p_kbit;
        n_cipher[w_slot] = r_p_kbit ^ r_plain[w_slot];
    end

    // map write: clearing sweep or marking the looked-up state
    always_comb begin
        if (i_cmd.clear) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
            w_wdata = '0;
        end else begin
            w_we    = r_p_valid;
            w_waddr = r_p_row;
            w_wdata = {r_epoch, w_new_bits};
        end
    end

    geffe_ram #(
        .WIDTH(ROW_W),
        .DEPTH(ROW_DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_rd_row),
        .o_rdata (w_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taps_one    <= TAPS_ONE_RST;
            r_taps_two    <= TAPS_TWO_RST;
            r_taps_three  <= TAPS_THREE_RST;
            r_seed_one    <= SEED_ONE_RST;
            r_seed_two    <= SEED_TWO_RST;
            r_seed_three  <= SEED_THREE_RST;
            r_shift_one   <= SEED_ONE_RST;
            r_shift_two   <= SEED_TWO_RST;
            r_shift_three <= SEED_THREE_RST;
            r_epoch       <= EPOCH_W'(1);
            r_clr_addr    <= '0;
            r_exh         <= 1'b0;
            r_cnt         <= '0;
            r_issue       <= '0;
            r_p_valid     <= 1'b0;
            r_byp_valid   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            // configuration writes, unknown indexes are dropped
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TAPS_ONE:   r_taps_one   <= i_cfg_data[LEN_ONE-1:0];
                    CFG_TAPS_TWO:   r_taps_two   <= i_cfg_data[LEN_TWO-1:0];
                    CFG_TAPS_THREE: r_taps_three <= i_cfg_data[LEN_THREE-1:0];
                    CFG_SEED_ONE:   r_seed_one   <= i_cfg_data[LEN_ONE-1:0];
                    CFG_SEED_TWO:   r_seed_two   <= i_cfg_data[LEN_TWO-1:0];
                    CFG_SEED_THREE: r_seed_three <= i_cfg_data[LEN_THREE-1:0];
                    default: ;
                endcase
            end

            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + ROW_AW'(1);
            end

            // new item: a new message reloads seeds and moves to a fresh epoch
            if (i_cmd.start) begin
                r_cnt       <= '0;
                r_issue     <= '0;
                r_p_valid   <= 1'b0;
                r_byp_valid <= 1'b0;
                if (i_first_byte) begin
                    r_shift_one   <= r_seed_one;
                    r_shift_two   <= r_seed_two;
                    r_shift_three <= r_seed_three;
                    r_exh         <= 1'b0;
                    r_epoch       <= (r_epoch == '1) ? EPOCH_W'(1) : r_epoch + EPOCH_W'(1);
                end
            end else begin
                // issue stage: read the map row and step the lfsrs
                if (w_issue) begin
                    r_shift_one   <= w_next_one;
                    r_shift_two   <= w_next_two;
                    r_shift_three <= w_next_three;
                    r_issue       <= r_issue + CNT_W'(1);
                end
                r_p_valid <= w_issue;

                // lookup stage: count the bit, a repeat ends the stream
                r_byp_valid <= r_p_valid;
                if (r_p_valid) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
                if (w_repeat) begin
                    r_exh <= 1'b1;
                end
            end

            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_plain  <= i_plain_byte;
            r_key    <= '0;
            r_cipher <= '0;
        end else if (r_p_valid) begin
            r_key    <= n_key;
            r_cipher <= n_cipher;
        end

        if (w_issue) begin
            r_p_row  <= w_rd_row;
            r_p_pos  <= w_rd_pos;
            r_p_kbit <= w_kbit;
            r_p_bit  <= r_issue[BIT_IDX_W-1:0];
        end

        if (r_p_valid) begin
            r_byp_row  <= r_p_row;
            r_byp_bits <= w_new_bits;
        end

        if (i_cmd.load_out) begin
            r_out_cipher <= r_cipher;
            r_out_key    <= r_key;
            r_out_cnt    <= r_cnt;
            r_out_exh    <= r_exh;
        end
    end

    assign o_sts.clear_last = (r_clr_addr == '1);
    assign o_sts.run_busy   = r_p_valid || ((r_issue != CNT_W'(BYTE_BITS)) && !r_exh);
    assign o_sts.epoch_full = (r_epoch == '1);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid        = r_out_valid;
    assign o_cipher_byte      = r_out_cipher;
    assign o_key_byte         = r_out_key;
    assign o_bits_valid       = r_out_cnt;
    assign o_stream_exhausted = r_out_exh;

endmodule

/* rtl/geffe_lfsr_stream_cipher.sv */
`timescale 1ns / 1ps

// Geffe generator stream cipher: each plaintext byte is encrypted msb first with one
// keystream bit per bit from three lfsrs (key = x3 ? x2 : x1). Every joined lfsr state
// is marked in a visited map held in a 8192 x 40 ram (32 state bits plus an 8-bit epoch
// tag per row); the bit whose state was already seen is still encrypted, then the
// stream ends and later bytes report zero valid bits until a byte with first_byte set
// reloads the seeds. The bit loop issues one map read per cycle with the
// read-modify-write of the row in the cycle after each read, so a full byte passes
// through the issue of its bits, a lookup behind the last issue and the load into the
// output register before the next byte is accepted. A byte cut short by a repeat
// finishes earlier, as fewer bits are issued, and a byte after the stream has ended
// issues no map reads and goes straight to the output register. One item is worked
// on at a time; a finished result waits in an output register while the next byte
// is accepted, and a result that finds the output register still full holds the
// block until the waiting one is taken. After reset the block runs a clearing sweep
// over all 8192 map rows before it takes its first item (configuration writes are
// taken throughout); the same sweep runs again on every 255th first_byte, when the
// epoch counter wraps, before that byte is processed.
module geffe_lfsr_stream_cipher import geffe_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    geffe_in_if.sink              i_in,
    geffe_out_if.source           o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    // sequencer
    geffe_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_first_byte (i_in.first_byte),
        .i_sts        (w_sts),
        .o_cmd        (w_cmd),
        .o_in_ready   (w_in_ready)
    );

    // lfsrs, visited map and result register
    geffe_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_plain_byte       (i_in.plain_byte),
        .i_first_byte       (i_in.first_byte),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_out_ready        (o_out.ready),
        .o_out_valid        (o_out.valid),
        .o_cipher_byte      (o_out.cipher_byte),
        .o_key_byte         (o_out.key_byte),
        .o_bits_valid       (o_out.bits_valid),
        .o_stream_exhausted (o_out.stream_exhausted)
    );

    assign i_in.ready = w_in_ready;

    // no item is taken while the map is being cleared
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clear |-> !i_in.ready)
        else $error("item accepted during map clearing");

    // one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("second item accepted while one is in work");

    // a short byte only happens when the stream has ended
    a_short_means_exhausted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.bits_valid != CNT_W'(BYTE_BITS))) |-> o_out.stream_exhausted)
        else $error("fewer than eight bits without exhaustion");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!o_out.valid || o_out.ready))
        else $error("result register overwritten");

endmodule

/* dv/geffe_lfsr_stream_cipher_tb.sv */
`timescale 1ns / 1ps

module geffe_lfsr_stream_cipher_tb;
    import geffe_pkg::*;

    // run control
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_ITEMS   = 150;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_REPORTS   = 50;
    localparam int TIMEOUT_NS    = 10_000_000;

    // register indexes that the block ignores
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(7);

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;
    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;

    typedef struct packed {
        logic [BYTE_W-1:0] cipher;
        logic [BYTE_W-1:0] key;
        logic [CNT_W-1:0]  count;
        logic              exhausted;
    } t_cipher_result;

    // one directed step: a register write or an item, with an optional typed result
    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] value;
        logic                  first;
        logic                  typed;
        t_cipher_result        want;
    } t_plan_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    geffe_in_if  in_ch();
    geffe_out_if out_ch();

    geffe_lfsr_stream_cipher dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predicted block state
    logic [LEN_ONE-1:0]   taps_one_q, seed_one_q, lfsr_one;
    logic [LEN_TWO-1:0]   taps_two_q, seed_two_q, lfsr_two;
    logic [LEN_THREE-1:0] taps_three_q, seed_three_q, lfsr_three;
    bit                   visited_states[int];
    logic                 stream_done;

    t_cipher_result expected_cipher_q[$];
    t_plan_row      plan[$];
    int             error_count = 0;
    int             send_idle_pct = 0;
    int             recv_stall_pct = 0;
    bit             hold_req = 1'b0;

    // one fibonacci step: shift right, parity of state and taps into the top bit
    function automatic logic [15:0] lfsr_next(input logic [15:0] r, input logic [15:0] taps,
                                              input int n);
        logic fb;
        fb = ^(r & taps);
        return (r >> 1) | (16'(fb) << (n - 1));
    endfunction

    // encrypt one byte msb first, updating the predicted state
    task automatic encrypt_byte(input logic [BYTE_W-1:0] pb, input logic fb,
                                output t_cipher_result r);
        logic [TOTAL_LEN-1:0] joined;
        logic                 x1, x2, x3, kb, seen_before;
        int                   b;
        r = '0;
        if (fb) begin
            lfsr_one   = seed_one_q;
            lfsr_two   = seed_two_q;
            lfsr_three = seed_three_q;
            visited_states.delete();
            stream_done = 1'b0;
        end
        for (b = 0; b < BYTE_BITS && !stream_done; b++) begin
            joined = {lfsr_one, lfsr_two, lfsr_three};
            seen_before = visited_states.exists(int'(joined));
            visited_states[int'(joined)] = 1'b1;
            x1 = lfsr_one[0];
            x2 = lfsr_two[0];
            x3 = lfsr_three[0];
            lfsr_one   = LEN_ONE'(lfsr_next(16'(lfsr_one), 16'(taps_one_q), LEN_ONE));
            lfsr_two   = LEN_TWO'(lfsr_next(16'(lfsr_two), 16'(taps_two_q), LEN_TWO));
            lfsr_three = LEN_THREE'(lfsr_next(16'(lfsr_three), 16'(taps_three_q), LEN_THREE));
            kb = x3 ? x2 : x1;
            r.key[BYTE_BITS-1-b]    = kb;
            r.cipher[BYTE_BITS-1-b] = pb[BYTE_BITS-1-b] ^ kb;
            r.count = r.count + 1'b1;
            if (seen_before) stream_done = 1'b1;
        end
        r.exhausted = stream_done;
    endtask

    // register write, mirrored into the predicted settings
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_TAPS_ONE:   taps_one_q   = data[LEN_ONE-1:0];
            CFG_TAPS_TWO:   taps_two_q   = data[LEN_TWO-1:0];
            CFG_TAPS_THREE: taps_three_q = data[LEN_THREE-1:0];
            CFG_SEED_ONE:   seed_one_q   = data[LEN_ONE-1:0];
            CFG_SEED_TWO:   seed_two_q   = data[LEN_TWO-1:0];
            CFG_SEED_THREE: seed_three_q = data[LEN_THREE-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // offer one item after a random gap, predict once accepted
    task automatic send_byte(input logic [BYTE_W-1:0] pb, input logic fb, input logic typed,
                             input t_cipher_result want);
        t_cipher_result r;
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.plain_byte <= pb;
        in_ch.first_byte <= fb;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        encrypt_byte(pb, fb, r);
        expected_cipher_q.push_back(typed ? want : r);
    endtask

    // stop offering and let every pending result come out
    task automatic drain_results();
        int waited;
        in_ch.valid <= 1'b0;
        for (waited = 0; expected_cipher_q.size() != 0 && waited < DRAIN_LIMIT; waited++)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_idle_mode(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 59; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 59; end
            default:   begin send_idle_pct = 8;  recv_stall_pct = 8;  end
        endcase
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin : receiver
        int held;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                for (held = 1; held < HOLD_CYCLES; held++) @(posedge i_clk);
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin : check_output
        t_cipher_result got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = {out_ch.cipher_byte, out_ch.key_byte, out_ch.bits_valid,
                   out_ch.stream_exhausted};
            if (expected_cipher_q.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: unexpected result cipher %h key %h bits %0d exhausted %0b",
                             $time, got.cipher, got.key, got.count, got.exhausted);
            end else begin
                want = expected_cipher_q.pop_front();
                if (got.cipher !== want.cipher || got.key !== want.key ||
                    got.count !== want.count || got.exhausted !== want.exhausted) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: mismatch exp %h %h %0d %0b got %h %h %0d %0b",
                                 $time, want.cipher, want.key, want.count, want.exhausted,
                                 got.cipher, got.key, got.count, got.exhausted);
                end
            end
        end
    end

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    // stimulus
    initial begin : stimulus
        logic [CFG_DATA_W-1:0] vals[6];
        int                    p, r, k, sent, msg_len;
        bit                    short_msgs;

        in_ch.valid      = 1'b0;
        in_ch.plain_byte = '0;
        in_ch.first_byte = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_rst_n    = 1'b0;

        taps_one_q   = TAPS_ONE_RST;
        taps_two_q   = TAPS_TWO_RST;
        taps_three_q = TAPS_THREE_RST;
        seed_one_q   = SEED_ONE_RST;
        seed_two_q   = SEED_TWO_RST;
        seed_three_q = SEED_THREE_RST;
        lfsr_one     = SEED_ONE_RST;
        lfsr_two     = SEED_TWO_RST;
        lfsr_three   = SEED_THREE_RST;
        stream_done  = 1'b0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, continuation, new message
        plan.push_back('{ROW_ITEM, CFG_TAPS_ONE, 8'h00, 1'b1, 1'b0, '0});
        plan.push_back('{ROW_ITEM, CFG_TAPS_ONE, 8'hFF, 1'b0, 1'b0, '0});
        plan.push_back('{ROW_ITEM, CFG_TAPS_ONE, 8'hA5, 1'b1, 1'b0, '0});
        // writes to unused indexes change nothing
        plan.push_back('{ROW_CFG, CFG_SPARE_A, 8'hFF, 1'b0, 1'b0, '0});
        plan.push_back('{ROW_CFG, CFG_SPARE_B, 8'h00, 1'b0, 1'b0, '0});
        plan.push_back('{ROW_ITEM, CFG_TAPS_ONE, 8'h3C, 1'b1, 1'b0, '0});
        // zero seeds, masked high bits; running lfsrs keep going until a new message
        plan.push_back('{ROW_CFG, CFG_SEED_ONE, 8'hF0, 1'b0, 1'b0, '0});
        plan.push_back('{ROW_CFG, CFG_SEED_TWO, 8'hC0, 1'b0, 1'b0, '0});
        plan.push_back('{ROW_CFG, CFG_SEED_THREE, 8'h00, 1'b0, 1'b0, '0});
        plan.push_back('{ROW_ITEM, CFG_TAPS_ONE, 8'h3C, 1'b0, 1'b0, '0});
        // all-zero state repeats at the second bit, then the stream is over
        plan.push_back('{ROW_ITEM, CFG_TAPS_ONE, 8'hFF, 1'b1, 1'b1,
                         '{8'hC0, 8'h00, 4'd2, 1'b1}});
        plan.push_back('{ROW_ITEM, CFG_TAPS_ONE, 8'hFF, 1'b0, 1'b1,
                         '{8'h00, 8'h00, 4'd0, 1'b1}});
        plan.push_back('{ROW_ITEM, CFG_TAPS_ONE, 8'h00, 1'b0, 1'b1,
                         '{8'h00, 8'h00, 4'd0, 1'b1}});
        plan.push_back('{ROW_ITEM, CFG_TAPS_ONE, 8'h80, 1'b1, 1'b1,
                         '{8'h80, 8'h00, 4'd2, 1'b1}});
        // every tap and seed at its top value
        plan.push_back('{ROW_CFG, CFG_TAPS_ONE, 8'hFF, 1'b0, 1'b0, '0});
        plan.push_back('{ROW_CFG, CFG_TAPS_TWO, 8'hFF, 1'b0, 1'b0, '0});
        plan.push_back('{ROW_CFG, CFG_TAPS_THREE, 8'hFF, 1'b0, 1'b0, '0});
        plan.push_back('{ROW_CFG, CFG_SEED_ONE, 8'hFF, 1'b0, 1'b0, '0});
        plan.push_back('{ROW_CFG, CFG_SEED_TWO, 8'hFF, 1'b0, 1'b0, '0});
        plan.push_back('{ROW_CFG, CFG_SEED_THREE, 8'hFF, 1'b0, 1'b0, '0});
        plan.push_back('{ROW_ITEM, CFG_TAPS_ONE, 8'h5A, 1'b1, 1'b0, '0});
        plan.push_back('{ROW_ITEM, CFG_TAPS_ONE, 8'hFF, 1'b0, 1'b0, '0});
        plan.push_back('{ROW_ITEM, CFG_TAPS_ONE, 8'h00, 1'b0, 1'b0, '0});
        plan.push_back('{ROW_ITEM, CFG_TAPS_ONE, 8'hC3, 1'b0, 1'b0, '0});
        // no taps: lfsrs drain to zero and the state repeats
        plan.push_back('{ROW_CFG, CFG_TAPS_ONE, 8'h00, 1'b0, 1'b0, '0});
        plan.push_back('{ROW_CFG, CFG_TAPS_TWO, 8'h00, 1'b0, 1'b0, '0});
        plan.push_back('{ROW_CFG, CFG_TAPS_THREE, 8'h00, 1'b0, 1'b0, '0});
        plan.push_back('{ROW_ITEM, CFG_TAPS_ONE, 8'hFF, 1'b1, 1'b0, '0});
        plan.push_back('{ROW_ITEM, CFG_TAPS_ONE, 8'h0F, 1'b0, 1'b0, '0});
        plan.push_back('{ROW_ITEM, CFG_TAPS_ONE, 8'hF0, 1'b0, 1'b0, '0});
        // back to the reset settings
        plan.push_back('{ROW_CFG, CFG_TAPS_ONE, CFG_DATA_W'(TAPS_ONE_RST), 1'b0, 1'b0, '0});
        plan.push_back('{ROW_CFG, CFG_TAPS_TWO, CFG_DATA_W'(TAPS_TWO_RST), 1'b0, 1'b0, '0});
        plan.push_back('{ROW_CFG, CFG_TAPS_THREE, CFG_DATA_W'(TAPS_THREE_RST), 1'b0, 1'b0,
                         '0});
        plan.push_back('{ROW_CFG, CFG_SEED_ONE, CFG_DATA_W'(SEED_ONE_RST), 1'b0, 1'b0, '0});
        plan.push_back('{ROW_CFG, CFG_SEED_TWO, CFG_DATA_W'(SEED_TWO_RST), 1'b0, 1'b0, '0});
        plan.push_back('{ROW_CFG, CFG_SEED_THREE, CFG_DATA_W'(SEED_THREE_RST), 1'b0, 1'b0,
                         '0});
        plan.push_back('{ROW_ITEM, CFG_TAPS_ONE, 8'h96, 1'b1, 1'b0, '0});

        @(posedge i_clk);
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                drain_results();
                cfg_write(plan[i].reg_idx, plan[i].value);
            end else begin
                send_byte(plan[i].value, plan[i].first, plan[i].typed, plan[i].want);
            end
        end

        // random phases: new settings and idle mode each, messages with random content
        for (p = 0; p < PHASE_COUNT; p++) begin
            drain_results();
            for (r = 0; r < 6; r++) vals[r] = CFG_DATA_W'($urandom_range(255));
            if (p == 0) begin
                for (r = 0; r < 6; r++) vals[r] = '1;
            end else if (p == 3) begin
                for (r = 0; r <= CFG_TAPS_THREE; r++) vals[r] = '0;
            end
            for (r = 0; r <= CFG_SEED_THREE; r++) cfg_write(CFG_IDX_W'(r), vals[r]);
            set_idle_mode(t_idle_mode'(p % 4));
            short_msgs = p[0];
            // long hold-off at the receiver while the sender keeps offering items
            if (p == 4) hold_req = 1'b1;

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(9) == 0) begin
                    // stray item, new message or not
                    send_byte(BYTE_W'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0);
                    sent++;
                end else begin
                    if (short_msgs)
                        msg_len = $urandom_range(1, 3);
                    else if ($urandom_range(9) < 7)
                        msg_len = $urandom_range(4, 24);
                    else
                        msg_len = $urandom_range(25, 120);
                    for (k = 0; k < msg_len && sent < PHASE_ITEMS; k++) begin
                        send_byte(BYTE_W'($urandom_range(255)), k == 0, 1'b0, '0);
                        sent++;
                    end
                end
            end
        end

        // wind down and report
        drain_results();
        if (expected_cipher_q.size() != 0) begin
            error_count += expected_cipher_q.size();
            $display("%0t: %0d expected results never arrived", $time,
                     expected_cipher_q.size());
        end
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
